[rtl/clc_pkg.sv]
// ----------------------------------------------------------------------------
// clc_pkg
// Shared types and constants of the combination lock controller.
// ----------------------------------------------------------------------------
`default_nettype none

package clc_pkg;

    // Code length and derived widths
    localparam int CODE_DIGITS = 3;
    localparam int DIGIT_W     = 8;
    localparam int POS_W       = $clog2(CODE_DIGITS + 1);
    localparam int ATT_W       = 4;
    localparam int TICK_W      = 16;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_TRY_LIMIT     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_SUCCESS_TICKS = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_ERROR_TICKS   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT_TICKS = CFG_IDX_W'(3);

    // Register reset values
    localparam logic [ATT_W-1:0]  TRY_LIMIT_RST     = ATT_W'(3);
    localparam logic [TICK_W-1:0] SUCCESS_TICKS_RST = TICK_W'(50);
    localparam logic [TICK_W-1:0] ERROR_TICKS_RST   = TICK_W'(50);
    localparam logic [TICK_W-1:0] LOCKOUT_TICKS_RST = TICK_W'(500);

    typedef logic [DIGIT_W-1:0] digit_t;
    typedef digit_t [CODE_DIGITS-1:0] code_t;

    // Factory code 12, 25, 7; any further digits are zero
    function automatic code_t reset_code();
        code_t c;
        c = '0;
        c[0] = DIGIT_W'(12);
        if (CODE_DIGITS > 1) c[1 % CODE_DIGITS] = DIGIT_W'(25);
        if (CODE_DIGITS > 2) c[2 % CODE_DIGITS] = DIGIT_W'(7);
        return c;
    endfunction

    typedef enum logic [2:0] {
        MODE_ENTRY   = 3'd0,
        MODE_VERIFY  = 3'd1,
        MODE_SUCCESS = 3'd2,
        MODE_ERROR   = 3'd3,
        MODE_LOCKOUT = 3'd4,
        MODE_CHANGE  = 3'd5,
        MODE_SAVE    = 3'd6
    } mode_t;

    typedef struct packed {
        logic [2:0]       mode;
        logic [1:0]       digit_position;
        logic [ATT_W-1:0] attempts_left;
        digit_t           shown_value;
    } result_t;

endpackage

`default_nettype wire

[rtl/combination_lock_controller_unit.sv]
// ----------------------------------------------------------------------------
// combination_lock_controller_unit
// Each result is registered: in the result register, or the skid if it is held.
// Throughput: one request per cycle while in_stall is low; state updates at accept.
// A two-entry output buffer (result register plus skid) lets a request be
// taken while a finished result still waits; in_stall rises only when both
// are full. Reset: entry mode, code 12,25,7, three tries, default timings.
// ----------------------------------------------------------------------------
`default_nettype none

module combination_lock_controller_unit
    import clc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    // configuration writes
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,

    // input requests (one per tick)
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [DIGIT_W-1:0]    dial_value,
    input  wire logic                  confirm_pulse,
    input  wire logic                  change_switch,

    // results
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [2:0]                 mode,
    output logic [1:0]                 digit_position,
    output logic [ATT_W-1:0]           attempts_left,
    output logic [DIGIT_W-1:0]         shown_value
);

    // ------------------------------------------------------------------
    // Configuration registers; the port never back-pressures.
    // ------------------------------------------------------------------
    logic [ATT_W-1:0]  try_limit_reg;
    logic [TICK_W-1:0] success_ticks_reg;
    logic [TICK_W-1:0] error_ticks_reg;
    logic [TICK_W-1:0] lockout_ticks_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            try_limit_reg     <= TRY_LIMIT_RST;
            success_ticks_reg <= SUCCESS_TICKS_RST;
            error_ticks_reg   <= ERROR_TICKS_RST;
            lockout_ticks_reg <= LOCKOUT_TICKS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_TRY_LIMIT:     try_limit_reg     <= cfg_data[ATT_W-1:0];
                CFG_SUCCESS_TICKS: success_ticks_reg <= cfg_data[TICK_W-1:0];
                CFG_ERROR_TICKS:   error_ticks_reg   <= cfg_data[TICK_W-1:0];
                CFG_LOCKOUT_TICKS: lockout_ticks_reg <= cfg_data[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Lock state
    // ------------------------------------------------------------------
    mode_t             lock_mode_reg,     lock_mode_next;
    code_t             saved_code_reg,    saved_code_next;
    code_t             typed_code_reg,    typed_code_next;
    code_t             pending_code_reg,  pending_code_next;
    logic [POS_W-1:0]  entry_pos_reg,     entry_pos_next;
    logic [ATT_W-1:0]  tries_left_reg,    tries_left_next;
    logic [TICK_W-1:0] feedback_cnt_reg,  feedback_cnt_next;
    logic [TICK_W-1:0] lockout_cnt_reg,   lockout_cnt_next;

    // Output buffer: result register and skid entry
    logic    out_valid_reg,  out_valid_next;
    result_t out_data_reg,   out_data_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t skid_data_reg,  skid_data_next;

    logic    in_accept;
    logic    out_take;
    logic    code_match;
    logic    digit_room;
    result_t result_new;

    // Skid full means the result register is full and stalled too.
    assign in_stall  = skid_valid_reg;
    assign in_accept = in_valid && !in_stall;
    assign out_take  = out_valid_reg && !out_stall;

    // Digit-wise compare of typed against saved code
    always_comb
    begin
        code_match = 1'b1;
        for (int i = 0; i < CODE_DIGITS; i++)
        begin
            if (typed_code_reg[i] != saved_code_reg[i])
                code_match = 1'b0;
        end
    end

    assign digit_room = (entry_pos_reg < POS_W'(CODE_DIGITS));

    // ------------------------------------------------------------------
    // Next-state logic for one tick
    // ------------------------------------------------------------------
    always_comb
    begin
        lock_mode_next    = lock_mode_reg;
        saved_code_next   = saved_code_reg;
        typed_code_next   = typed_code_reg;
        pending_code_next = pending_code_reg;
        entry_pos_next    = entry_pos_reg;
        tries_left_next   = tries_left_reg;
        feedback_cnt_next = feedback_cnt_reg;
        lockout_cnt_next  = lockout_cnt_reg;

        case (lock_mode_reg)
            MODE_ENTRY:
            begin
                if (confirm_pulse)
                begin
                    if (digit_room)
                    begin
                        typed_code_next[entry_pos_reg[$clog2(CODE_DIGITS > 1 ?
                            CODE_DIGITS : 2)-1:0]] = dial_value;
                        entry_pos_next = entry_pos_reg + POS_W'(1);
                    end
                    if (entry_pos_next >= POS_W'(CODE_DIGITS))
                        lock_mode_next = MODE_VERIFY;
                end
            end
            MODE_VERIFY:
            begin
                if (code_match)
                begin
                    lock_mode_next    = MODE_SUCCESS;
                    feedback_cnt_next = success_ticks_reg;
                end
                else if (tries_left_reg <= ATT_W'(1))
                begin
                    // last try used up: lock out
                    tries_left_next  = '0;
                    lock_mode_next   = MODE_LOCKOUT;
                    lockout_cnt_next = lockout_ticks_reg;
                end
                else
                begin
                    tries_left_next   = tries_left_reg - ATT_W'(1);
                    lock_mode_next    = MODE_ERROR;
                    feedback_cnt_next = error_ticks_reg;
                end
            end
            MODE_SUCCESS:
            begin
                if (feedback_cnt_reg != '0)
                    feedback_cnt_next = feedback_cnt_reg - TICK_W'(1);
                else
                begin
                    tries_left_next = try_limit_reg;
                    entry_pos_next  = '0;
                    // change switch is only looked at here
                    if (change_switch)
                    begin
                        pending_code_next = '0;
                        lock_mode_next    = MODE_CHANGE;
                    end
                    else
                    begin
                        typed_code_next = '0;
                        lock_mode_next  = MODE_ENTRY;
                    end
                end
            end
            MODE_ERROR:
            begin
                if (feedback_cnt_reg != '0)
                    feedback_cnt_next = feedback_cnt_reg - TICK_W'(1);
                else
                begin
                    typed_code_next = '0;
                    entry_pos_next  = '0;
                    lock_mode_next  = MODE_ENTRY;
                end
            end
            MODE_LOCKOUT:
            begin
                if (lockout_cnt_reg != '0)
                    lockout_cnt_next = lockout_cnt_reg - TICK_W'(1);
                else
                begin
                    tries_left_next = try_limit_reg;
                    typed_code_next = '0;
                    entry_pos_next  = '0;
                    lock_mode_next  = MODE_ENTRY;
                end
            end
            MODE_CHANGE:
            begin
                if (confirm_pulse)
                begin
                    if (digit_room)
                    begin
                        pending_code_next[entry_pos_reg[$clog2(CODE_DIGITS > 1 ?
                            CODE_DIGITS : 2)-1:0]] = dial_value;
                        entry_pos_next = entry_pos_reg + POS_W'(1);
                    end
                    if (entry_pos_next >= POS_W'(CODE_DIGITS))
                        lock_mode_next = MODE_SAVE;
                end
            end
            MODE_SAVE:
            begin
                saved_code_next   = pending_code_reg;
                lock_mode_next    = MODE_SUCCESS;
                feedback_cnt_next = success_ticks_reg;
            end
            default:
            begin
                // undefined mode code: back to entry with a clean buffer
                typed_code_next = '0;
                entry_pos_next  = '0;
                lock_mode_next  = MODE_ENTRY;
            end
        endcase

        result_new.mode           = lock_mode_next;
        result_new.digit_position = entry_pos_next[1:0];
        result_new.attempts_left  = tries_left_next;
        result_new.shown_value    = dial_value;
    end

    // ------------------------------------------------------------------
    // Output buffer control
    // ------------------------------------------------------------------
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;

        if (!out_valid_reg || out_take)
        begin
            // result register free this cycle: drain skid first
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = in_accept;
                out_data_next  = result_new;
            end
        end
        else if (in_accept)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = result_new;
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lock_mode_reg    <= MODE_ENTRY;
            saved_code_reg   <= reset_code();
            typed_code_reg   <= '0;
            pending_code_reg <= '0;
            entry_pos_reg    <= '0;
            tries_left_reg   <= TRY_LIMIT_RST;
            feedback_cnt_reg <= '0;
            lockout_cnt_reg  <= '0;
            out_valid_reg    <= 1'b0;
            skid_valid_reg   <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                lock_mode_reg    <= lock_mode_next;
                saved_code_reg   <= saved_code_next;
                typed_code_reg   <= typed_code_next;
                pending_code_reg <= pending_code_next;
                entry_pos_reg    <= entry_pos_next;
                tries_left_reg   <= tries_left_next;
                feedback_cnt_reg <= feedback_cnt_next;
                lockout_cnt_reg  <= lockout_cnt_next;
            end
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid      = out_valid_reg;
    assign mode           = out_data_reg.mode;
    assign digit_position = out_data_reg.digit_position;
    assign attempts_left  = out_data_reg.attempts_left;
    assign shown_value    = out_data_reg.shown_value;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // skid only fills behind a full result register
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while result register empty");

    // an accepted request always leaves a result behind
    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> out_valid_reg)
        else $error("accepted request produced no result");

    // verify is only reached with a complete code typed
    a_verify_full_code: assert property (@(posedge clk) disable iff (!rst_n)
        (lock_mode_reg == MODE_VERIFY) |-> (entry_pos_reg == POS_W'(CODE_DIGITS)))
        else $error("verify entered with incomplete code");

    // digit count never runs past the code length
    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        entry_pos_reg <= POS_W'(CODE_DIGITS))
        else $error("entry position beyond code length");

endmodule

`default_nettype wire
